// ----- sv/rau_pkg.sv -----
// Shared types and constants of the rational arithmetic unit.
// Used by the channel interfaces, the controller, the datapath and the top level.
// No dependencies.
package rau_pkg;

	localparam int FIELD_W = 16;  // width of each operand field on the request channel
	localparam int RES_W   = 33;  // width of res_num and res_den
	localparam int OP_W    = 3;
	localparam int ORD_W   = 2;

	localparam logic [OP_W-1:0] OP_ADD = 3'd0;
	localparam logic [OP_W-1:0] OP_SUB = 3'd1;
	localparam logic [OP_W-1:0] OP_MUL = 3'd2;
	localparam logic [OP_W-1:0] OP_DIV = 3'd3;
	localparam logic [OP_W-1:0] OP_CMP = 3'd4;
	localparam logic [OP_W-1:0] OP_RED = 3'd5;

	localparam logic signed [ORD_W-1:0] ORD_EQ = 2'sb00;
	localparam logic signed [ORD_W-1:0] ORD_GT = 2'sb01;
	localparam logic signed [ORD_W-1:0] ORD_LT = 2'sb11;

	// controller -> datapath
	typedef struct packed {
		logic load;      // capture a request beat
		logic mul_step;  // one product into its register
		logic gcd_step;  // one binary gcd step
		logic div_init;  // latch gcd, start both dividers
		logic div_step;  // one quotient bit in each divider
		logic out_load;  // fill the response register
	} rau_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic reduce_op;
		logic mul_last;
		logic gcd_done;
		logic div_last;
	} rau_sts_t;

endpackage

// ----- sv/rau_if.sv -----
// Request and response channel interfaces of the rational arithmetic unit.
// Depends on rau_pkg.
interface rau_req_if import rau_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic [OP_W-1:0]           operation;
	logic signed [FIELD_W-1:0] a_num;
	logic signed [FIELD_W-1:0] a_den;
	logic signed [FIELD_W-1:0] b_num;
	logic signed [FIELD_W-1:0] b_den;

	modport source (output valid, operation, a_num, a_den, b_num, b_den, input ready);
	modport sink   (input valid, operation, a_num, a_den, b_num, b_den, output ready);
endinterface

interface rau_rsp_if import rau_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic signed [RES_W-1:0] res_num;
	logic signed [RES_W-1:0] res_den;
	logic signed [ORD_W-1:0] order;
	logic                    zero_fraction_error;

	modport source (output valid, res_num, res_den, order, zero_fraction_error, input ready);
	modport sink   (input valid, res_num, res_den, order, zero_fraction_error, output ready);
endinterface

// ----- sv/rational_arithmetic_unit_top.sv -----
// Rational arithmetic unit, top level: controller plus datapath.
// Depends on rau_pkg, rau_if (rau_req_if, rau_rsp_if), rau_ctrl and rau_dp.
//
// Usage
//   req: one beat carries an operation (add, subtract, multiply, divide,
//        compare, reduce a) and two signed fractions a_num/a_den, b_num/b_den.
//   rsp: one beat per request: res_num/res_den (33 bit), order (+1/0/-1 for
//        compare) and zero_fraction_error (reduce of 0/0, input passed through).
//   Operands are taken as the low OPERAND_WIDTH bits of each field.
// Sequence
//   One request in flight. Every request first forms three cross products in
//   the shared multiplier (one cross product per cycle), then loads the
//   response register once it has room; add/sub/mul/div/compare stop there.
//   Reduce adds the binary gcd (one step per cycle, at most
//   4*OPERAND_WIDTH steps), a latch of the gcd, and OPERAND_WIDTH quotient
//   bits from the two dividers running side by side.
//   The response register decouples the sides: the next request is taken as
//   soon as the result is loaded, even if rsp is stalled; a finished result
//   waits only while the previous one is still unread.
// Reset
//   arst_n clears the sequencer and rsp.valid; req.ready is high after reset.
module rational_arithmetic_unit_top import rau_pkg::*; #(
	parameter int OPERAND_WIDTH = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	rau_req_if.sink   req,
	rau_rsp_if.source rsp
);

	rau_cmd_t cmd;
	rau_sts_t sts;

	rau_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	rau_dp #(
		.OW (OPERAND_WIDTH)
	) u_dp (
		.clk                 (clk),
		.arst_n              (arst_n),
		.cmd                 (cmd),
		.sts                 (sts),
		.operation           (req.operation),
		.a_num               (req.a_num),
		.a_den               (req.a_den),
		.b_num               (req.b_num),
		.b_den               (req.b_den),
		.res_num             (rsp.res_num),
		.res_den             (rsp.res_den),
		.order               (rsp.order),
		.zero_fraction_error (rsp.zero_fraction_error)
	);

	// response register is never overwritten while it holds an unread beat
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!rsp.valid || rsp.ready))
		else $error("response overwritten while stalled");

	// a request beat closes the request channel until its result is loaded
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> !req.ready)
		else $error("second request taken while one is in flight");

	// a nonzero order only comes from compare, which leaves the fraction zero
	a_cmp_zero_frac: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.order != ORD_EQ) |-> (rsp.res_num == '0 && rsp.res_den == '0
		&& !rsp.zero_fraction_error))
		else $error("compare result carries a fraction");

	// reduce of 0/0 passes zero through
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.zero_fraction_error) |-> (rsp.res_num == '0 && rsp.res_den == '0))
		else $error("zero fraction error with nonzero result");

endmodule

// ----- sv/rau_ctrl.sv -----
// Sequencer of the rational arithmetic unit: walks one request through
// multiply, gcd and divide phases and owns the response valid. Depends on rau_pkg.
module rau_ctrl import rau_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	output logic     out_valid,
	input  logic     out_ready,
	input  rau_sts_t sts,
	output rau_cmd_t cmd
);

	typedef enum logic [2:0] {S_IDLE, S_MUL, S_GCD, S_DIV, S_DONE} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_MUL;
				end
			end
			S_MUL: begin
				cmd.mul_step = 1'b1;
				if (sts.mul_last) begin
					state_d = sts.reduce_op ? S_GCD : S_DONE;
				end
			end
			S_GCD: begin
				if (sts.gcd_done) begin
					cmd.div_init = 1'b1;
					state_d      = S_DIV;
				end else begin
					cmd.gcd_step = 1'b1;
				end
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				// wait for room in the response register
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

endmodule

// ----- sv/rau_dp.sv -----
// Datapath of the rational arithmetic unit: operand registers, one shared
// multiplier, binary gcd, two shift-subtract dividers and the response register.
// Depends on rau_pkg; sequenced by rau_ctrl.
module rau_dp import rau_pkg::*; #(
	parameter int OW = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  rau_cmd_t                  cmd,
	output rau_sts_t                  sts,
	input  logic [OP_W-1:0]           operation,
	input  logic signed [FIELD_W-1:0] a_num,
	input  logic signed [FIELD_W-1:0] a_den,
	input  logic signed [FIELD_W-1:0] b_num,
	input  logic signed [FIELD_W-1:0] b_den,
	output logic signed [RES_W-1:0]   res_num,
	output logic signed [RES_W-1:0]   res_den,
	output logic signed [ORD_W-1:0]   order,
	output logic                      zero_fraction_error
);

	localparam int PW = 2 * OW;
	localparam int LW = (2 * OW + 1 > RES_W) ? 2 * OW + 1 : RES_W;
	localparam int XF = (OW > FIELD_W) ? OW : FIELD_W;
	localparam int CW = $clog2(OW);
	localparam int KW = $clog2(OW + 1);

	// low OW bits of the field; fields narrower than OW zero-extend
	function automatic logic signed [OW-1:0] ext_op(input logic [FIELD_W-1:0] f);
		logic [XF-1:0] z;
		z = XF'(f);
		return z[OW-1:0];
	endfunction

	function automatic logic [OW-1:0] mag(input logic signed [OW-1:0] x);
		return x[OW-1] ? (~x + 1'b1) : x;
	endfunction

	// one restoring division step: {quotient bit, new remainder}
	function automatic logic [OW:0] div_bit(input logic [OW-1:0] rem, input logic nb,
			input logic [OW-1:0] dvs);
		logic [OW:0] t;
		logic [OW:0] s;
		t = {rem, nb};
		s = t - {1'b0, dvs};
		if (t >= {1'b0, dvs}) begin
			return {1'b1, s[OW-1:0]};
		end else begin
			return {1'b0, t[OW-1:0]};
		end
	endfunction

	logic [OP_W-1:0]        op_q;
	logic signed [OW-1:0]   an_q, ad_q, bn_q, bd_q;
	logic [1:0]             mcnt_q;
	logic signed [PW-1:0]   p1_q, p2_q, p3_q;
	logic [OW-1:0]          u_q, v_q;
	logic [KW-1:0]          k_q;
	logic [OW-1:0]          g_q;
	logic [OW-1:0]          dvn_q, dvd_q, rmn_q, rmd_q;
	logic [CW-1:0]          dcnt_q;
	logic signed [RES_W-1:0] res_num_q, res_den_q;
	logic signed [ORD_W-1:0] order_q;
	logic                   err_q;

	// shared multiplier, one product per cycle
	logic signed [OW-1:0] ma, mb;
	logic signed [PW-1:0] prod;

	always_comb begin
		unique case (mcnt_q)
			2'd0: begin
				ma = an_q;
				mb = (op_q == OP_MUL) ? bn_q : bd_q;
			end
			2'd1: begin
				ma = bn_q;
				mb = ad_q;
			end
			default: begin
				ma = ad_q;
				mb = bd_q;
			end
		endcase
	end

	assign prod = ma * mb;

	logic [OW:0] nstep, dstep;
	assign nstep = div_bit(rmn_q, dvn_q[OW-1], g_q);
	assign dstep = div_bit(rmd_q, dvd_q[OW-1], g_q);

	// response formatting
	logic signed [LW-1:0]    e1, e2, e3, rn, rd;
	logic signed [OW:0]      sqn, sqd;
	logic signed [ORD_W-1:0] ord;
	logic                    err;

	assign e1  = {{(LW-PW){p1_q[PW-1]}}, p1_q};
	assign e2  = {{(LW-PW){p2_q[PW-1]}}, p2_q};
	assign e3  = {{(LW-PW){p3_q[PW-1]}}, p3_q};
	assign sqn = an_q[OW-1] ? (~{1'b0, dvn_q} + 1'b1) : {1'b0, dvn_q};
	assign sqd = ad_q[OW-1] ? (~{1'b0, dvd_q} + 1'b1) : {1'b0, dvd_q};

	always_comb begin
		rn  = '0;
		rd  = '0;
		ord = ORD_EQ;
		err = 1'b0;
		unique case (op_q)
			OP_ADD: begin
				rn = e1 + e2;
				rd = e3;
			end
			OP_SUB: begin
				rn = e1 - e2;
				rd = e3;
			end
			OP_MUL: begin
				rn = e1;
				rd = e3;
			end
			OP_DIV: begin
				rn = e1;
				rd = e2;
			end
			OP_CMP: begin
				if (p1_q > p2_q) begin
					ord = ORD_GT;
				end else if (p1_q < p2_q) begin
					ord = ORD_LT;
				end
			end
			OP_RED: begin
				if (g_q == '0) begin
					// 0/0: pass through
					err = 1'b1;
					rn  = {{(LW-OW){an_q[OW-1]}}, an_q};
					rd  = {{(LW-OW){ad_q[OW-1]}}, ad_q};
				end else begin
					rn = {{(LW-OW-1){sqn[OW]}}, sqn};
					rd = {{(LW-OW-1){sqd[OW]}}, sqd};
				end
			end
			default: begin
				rn = '0;
				rd = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q   <= OP_ADD;
			mcnt_q <= '0;
			dcnt_q <= '0;
		end else begin
			if (cmd.load) begin
				op_q   <= operation;
				mcnt_q <= '0;
			end else if (cmd.mul_step) begin
				mcnt_q <= mcnt_q + 2'd1;
			end
			if (cmd.div_init) begin
				dcnt_q <= '0;
			end else if (cmd.div_step) begin
				dcnt_q <= dcnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			an_q <= ext_op(a_num);
			ad_q <= ext_op(a_den);
			bn_q <= ext_op(b_num);
			bd_q <= ext_op(b_den);
			u_q  <= mag(ext_op(a_num));
			v_q  <= mag(ext_op(a_den));
			k_q  <= '0;
		end
		if (cmd.mul_step) begin
			unique case (mcnt_q)
				2'd0:    p1_q <= prod;
				2'd1:    p2_q <= prod;
				default: p3_q <= prod;
			endcase
		end
		if (cmd.gcd_step) begin
			// Stein: strip common twos, then single twos, then subtract odd values
			priority if (!u_q[0] && !v_q[0]) begin
				u_q <= u_q >> 1;
				v_q <= v_q >> 1;
				k_q <= k_q + 1'b1;
			end else if (!u_q[0]) begin
				u_q <= u_q >> 1;
			end else if (!v_q[0]) begin
				v_q <= v_q >> 1;
			end else if (u_q >= v_q) begin
				u_q <= u_q - v_q;
			end else begin
				v_q <= v_q - u_q;
			end
		end
		if (cmd.div_init) begin
			g_q   <= (u_q | v_q) << k_q;
			dvn_q <= mag(an_q);
			dvd_q <= mag(ad_q);
			rmn_q <= '0;
			rmd_q <= '0;
		end else if (cmd.div_step) begin
			dvn_q <= {dvn_q[OW-2:0], nstep[OW]};
			dvd_q <= {dvd_q[OW-2:0], dstep[OW]};
			rmn_q <= nstep[OW-1:0];
			rmd_q <= dstep[OW-1:0];
		end
		if (cmd.out_load) begin
			res_num_q <= rn[RES_W-1:0];
			res_den_q <= rd[RES_W-1:0];
			order_q   <= ord;
			err_q     <= err;
		end
	end

	assign sts.reduce_op = (op_q == OP_RED);
	assign sts.mul_last  = (mcnt_q == 2'd2);
	assign sts.gcd_done  = (u_q == '0) || (v_q == '0);
	assign sts.div_last  = (dcnt_q == CW'(OW - 1));

	assign res_num             = res_num_q;
	assign res_den             = res_den_q;
	assign order               = order_q;
	assign zero_fraction_error = err_q;

endmodule

// ----- tb/rational_arithmetic_unit_top_tb.sv -----
// Testbench for rational_arithmetic_unit_top: directed and random fraction requests.
// Each request beat is predicted and checked against the response beats in order.
// Depends on rau_pkg, rau_if (rau_req_if, rau_rsp_if) and the unit RTL.
module rational_arithmetic_unit_top_tb;
	import rau_pkg::*;

	localparam int OPERAND_WIDTH = 16;
	localparam int HALF_PERIOD   = 6;
	localparam int RESET_CYCLES  = 9;
	localparam int RANDOM_ITEMS  = 950;
	localparam int MAX_WAIT      = 17;
	// drain well past the slowest reduce request
	localparam int DRAIN_CYCLES  = 200;
	// slowest beat gap: reduce latency + sender gap + receiver stall, taken many times over
	localparam int STALL_LIMIT   = 3000;

	typedef struct {
		logic [OP_W-1:0]           operation;
		logic signed [FIELD_W-1:0] a_num;
		logic signed [FIELD_W-1:0] a_den;
		logic signed [FIELD_W-1:0] b_num;
		logic signed [FIELD_W-1:0] b_den;
	} fraction_request_t;

	typedef struct {
		logic signed [RES_W-1:0] res_num;
		logic signed [RES_W-1:0] res_den;
		logic signed [ORD_W-1:0] order;
		logic                    zero_fraction_error;
	} fraction_result_t;

	logic clk = 1'b0;
	logic arst_n;

	rau_req_if req ();
	rau_rsp_if rsp ();

	rational_arithmetic_unit_top #(
		.OPERAND_WIDTH(OPERAND_WIDTH)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req),
		.rsp   (rsp)
	);

	always #HALF_PERIOD clk = ~clk;

	fraction_request_t pending_requests[$];   // stimulus not yet driven
	fraction_result_t  expected_results[$];   // predictions awaiting a response beat
	fraction_request_t next_request;
	fraction_request_t taken_request;
	fraction_result_t  got_result;
	fraction_result_t  want_result;

	int req_beats;     // accepted request beats (posedge side)
	int rsp_beats;     // accepted response beats (posedge side)
	int req_seen;      // driver copies of the counters
	int rsp_seen;
	int req_gap;
	int rsp_hold;
	bit presenting;
	int total_items;
	int failures;
	int idle_cycles;

	// Operand as the DUT sees it: field bits, low OPERAND_WIDTH kept, sign-extended.
	function automatic longint operand_value(logic signed [FIELD_W-1:0] field);
		longint v;
		v = longint'($unsigned(field));
		v = v <<< (64 - OPERAND_WIDTH);
		return v >>> (64 - OPERAND_WIDTH);
	endfunction

	// Cross-multiplied result of one request; no reduction except for OP_RED.
	function automatic fraction_result_t rational_result(fraction_request_t rq);
		longint an, ad, bn, bd, cross_a, cross_b;
		longint unsigned mag_n, mag_d, g, rem, tmp;
		fraction_result_t r;
		an = operand_value(rq.a_num);
		ad = operand_value(rq.a_den);
		bn = operand_value(rq.b_num);
		bd = operand_value(rq.b_den);
		cross_a = an * bd;
		cross_b = bn * ad;
		r.res_num = '0;
		r.res_den = '0;
		r.order = ORD_EQ;
		r.zero_fraction_error = 1'b0;
		case (rq.operation)
			OP_ADD: begin
				r.res_num = RES_W'(cross_a + cross_b);
				r.res_den = RES_W'(ad * bd);
			end
			OP_SUB: begin
				r.res_num = RES_W'(cross_a - cross_b);
				r.res_den = RES_W'(ad * bd);
			end
			OP_MUL: begin
				r.res_num = RES_W'(an * bn);
				r.res_den = RES_W'(ad * bd);
			end
			OP_DIV: begin
				r.res_num = RES_W'(cross_a);
				r.res_den = RES_W'(cross_b);
			end
			OP_CMP: begin
				// raw cross products, denominator signs not normalized
				if (cross_a > cross_b)
					r.order = ORD_GT;
				else if (cross_a < cross_b)
					r.order = ORD_LT;
			end
			OP_RED: begin
				mag_n = (an < 0) ? longint'(-an) : an;
				mag_d = (ad < 0) ? longint'(-ad) : ad;
				g = mag_n;
				rem = mag_d;
				while (rem != 0) begin
					tmp = g % rem;
					g = rem;
					rem = tmp;
				end
				if (g == 0) begin
					// 0/0: flag and pass a through
					r.zero_fraction_error = 1'b1;
					r.res_num = RES_W'(an);
					r.res_den = RES_W'(ad);
				end else begin
					r.res_num = RES_W'((an < 0) ? -longint'(mag_n / g) : longint'(mag_n / g));
					r.res_den = RES_W'((ad < 0) ? -longint'(mag_d / g) : longint'(mag_d / g));
				end
			end
			default: ;  // unused codes: all zero
		endcase
		return r;
	endfunction

	task automatic add_request(logic [OP_W-1:0] op, int an, int ad, int bn, int bd);
		fraction_request_t rq;
		rq.operation = op;
		rq.a_num = FIELD_W'(an);
		rq.a_den = FIELD_W'(ad);
		rq.b_num = FIELD_W'(bn);
		rq.b_den = FIELD_W'(bd);
		pending_requests.push_back(rq);
	endtask

	// Mix of full-range, small and extreme operand values.
	function automatic logic signed [FIELD_W-1:0] random_field();
		logic signed [FIELD_W-1:0] f;
		case ($urandom_range(0, 3))
			0, 1: f = FIELD_W'($urandom);
			2: f = FIELD_W'($urandom_range(0, 40) - 20);
			default: begin
				case ($urandom_range(0, 5))
					0: f = FIELD_W'(-32768);
					1: f = FIELD_W'(-32767);
					2: f = FIELD_W'(-1);
					3: f = FIELD_W'(0);
					4: f = FIELD_W'(1);
					default: f = FIELD_W'(32767);
				endcase
			end
		endcase
		return f;
	endfunction

	function automatic int signed_small(int hi);
		int v;
		v = $urandom_range(0, hi);
		return $urandom_range(0, 1) ? -v : v;
	endfunction

	task automatic add_random_request();
		fraction_request_t rq;
		int k, x, y;
		if ($urandom_range(0, 19) == 0)
			rq.operation = OP_W'($urandom_range(6, 7));
		else
			rq.operation = OP_W'($urandom_range(OP_ADD, OP_RED));
		rq.a_num = random_field();
		rq.a_den = random_field();
		rq.b_num = random_field();
		rq.b_den = random_field();
		// reduce: plant a common factor so the gcd is nontrivial
		if (rq.operation == OP_RED && $urandom_range(0, 1)) begin
			k = $urandom_range(1, 181);
			x = signed_small(181);
			y = signed_small(181);
			rq.a_num = FIELD_W'(k * x);
			rq.a_den = FIELD_W'(k * y);
		end
		// compare: equal ratios, possibly with flipped signs
		if (rq.operation == OP_CMP && $urandom_range(0, 2) == 0) begin
			x = signed_small(200);
			y = signed_small(200);
			k = signed_small(150);
			rq.a_num = FIELD_W'(x);
			rq.a_den = FIELD_W'(y);
			rq.b_num = FIELD_W'(x * k);
			rq.b_den = FIELD_W'(y * k);
		end
		pending_requests.push_back(rq);
	endtask

	// Wait cycles for the next beat; every fourth stretch of 40 beats runs flat out.
	function automatic int draw_wait(int beat_idx);
		if ((beat_idx / 40) % 4 == 3)
			return 0;
		return $urandom_range(0, 1) ? $urandom_range(0, MAX_WAIT) : 0;
	endfunction

	// Known values before the first falling edge.
	initial begin
		req.valid = 1'b0;
		req.operation = '0;
		req.a_num = '0;
		req.a_den = '0;
		req.b_num = '0;
		req.b_den = '0;
		rsp.ready = 1'b0;
	end

	// Request driver: one beat at a time from pending_requests, gap drawn per beat.
	always @(negedge clk) begin
		if (!arst_n) begin
			req.valid <= 1'b0;
		end else begin
			if (req_beats != req_seen) begin
				req_seen = req_beats;
				presenting = 1'b0;
				req_gap = draw_wait(req_seen);
			end
			if (!presenting) begin
				if (req_gap > 0) begin
					req_gap--;
					req.valid <= 1'b0;
				end else if (pending_requests.size() != 0) begin
					next_request = pending_requests.pop_front();
					req.operation <= next_request.operation;
					req.a_num <= next_request.a_num;
					req.a_den <= next_request.a_den;
					req.b_num <= next_request.b_num;
					req.b_den <= next_request.b_den;
					req.valid <= 1'b1;
					presenting = 1'b1;
				end else begin
					req.valid <= 1'b0;
				end
			end
		end
	end

	// Response ready: a stall drawn after every accepted beat.
	always @(negedge clk) begin
		if (!arst_n) begin
			rsp.ready <= 1'b0;
		end else begin
			if (rsp_beats != rsp_seen) begin
				rsp_seen = rsp_beats;
				rsp_hold = draw_wait(rsp_seen + 20);
			end
			if (rsp_hold > 0) begin
				rsp_hold--;
				rsp.ready <= 1'b0;
			end else begin
				rsp.ready <= 1'b1;
			end
		end
	end

	// Beat monitor: predict on request beats, check response beats in order.
	always @(posedge clk) begin
		if (arst_n) begin
			if (req.valid && req.ready) begin
				taken_request.operation = req.operation;
				taken_request.a_num = req.a_num;
				taken_request.a_den = req.a_den;
				taken_request.b_num = req.b_num;
				taken_request.b_den = req.b_den;
				expected_results.push_back(rational_result(taken_request));
				req_beats <= req_beats + 1;
			end
			if (rsp.valid && rsp.ready) begin
				rsp_beats <= rsp_beats + 1;
				got_result.res_num = rsp.res_num;
				got_result.res_den = rsp.res_den;
				got_result.order = rsp.order;
				got_result.zero_fraction_error = rsp.zero_fraction_error;
				if (expected_results.size() == 0) begin
					$error("response beat with no request outstanding: res_num %0d res_den %0d",
						got_result.res_num, got_result.res_den);
					failures++;
				end else begin
					want_result = expected_results.pop_front();
					if (got_result.res_num !== want_result.res_num) begin
						$error("res_num: expected %0d, got %0d",
							want_result.res_num, got_result.res_num);
						failures++;
					end
					if (got_result.res_den !== want_result.res_den) begin
						$error("res_den: expected %0d, got %0d",
							want_result.res_den, got_result.res_den);
						failures++;
					end
					if (got_result.order !== want_result.order) begin
						$error("order: expected %0d, got %0d",
							want_result.order, got_result.order);
						failures++;
					end
					if (got_result.zero_fraction_error !== want_result.zero_fraction_error) begin
						$error("zero_fraction_error: expected %0d, got %0d",
							want_result.zero_fraction_error, got_result.zero_fraction_error);
						failures++;
					end
				end
			end
		end
	end

	// Watchdog: cycles without any accepted beat on either channel.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("FAIL rational_arithmetic_unit_top");
				$finish;
			end
		end
	end

	initial begin
		arst_n = 1'b0;

		// Directed: field extremes, every operation, the listed corner cases.
		add_request(OP_ADD, 32767, 32767, 32767, 32767);
		add_request(OP_ADD, -32768, -32768, -32768, -32768);  // sum reaches 2^31
		add_request(OP_ADD, 0, 0, 0, 0);
		add_request(OP_SUB, -32768, 32767, 32767, -32768);
		add_request(OP_SUB, 1, -1, -1, 1);
		add_request(OP_MUL, -32768, -32768, -32768, -32768);
		add_request(OP_MUL, 32767, -1, -32768, 1);
		add_request(OP_DIV, 1, 0, 0, 1);                      // zero divisor shows up as is
		add_request(OP_DIV, -32768, 1, -32768, 32767);
		add_request(OP_CMP, 1, 2, 2, 4);                      // equal
		add_request(OP_CMP, 3, 4, 1, 2);                      // greater
		add_request(OP_CMP, -1, 2, 1, 3);                     // smaller
		add_request(OP_CMP, 1, -2, 1, 3);                     // negative den, not normalized
		add_request(OP_CMP, -32768, 32767, 32767, -32768);
		add_request(OP_RED, 0, 0, 5, 7);                      // 0/0 flags error
		add_request(OP_RED, 0, -7, 0, 0);                     // zero numerator
		add_request(OP_RED, -12, 0, 0, 0);                    // zero denominator
		add_request(OP_RED, -32768, -32768, 0, 0);
		add_request(OP_RED, 12, -18, -1, -1);
		add_request(OP_RED, 32767, -32768, 0, 0);             // coprime
		add_request(OP_RED, -32768, 16384, 32767, 32767);
		add_request(OP_RED, 30, 45, -5, 9);
		add_request(3'd6, 32767, -32768, -1, 1);              // unused codes
		add_request(3'd7, -32768, 32767, 1, -1);

		repeat (RANDOM_ITEMS) add_random_request();
		total_items = pending_requests.size();

		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		wait (req_beats == total_items);
		wait (expected_results.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (failures == 0)
			$display("PASS rational_arithmetic_unit_top");
		else
			$display("FAIL rational_arithmetic_unit_top");
		$finish;
	end

endmodule
